### hw/rtl/clock_time_date_setter_core_defines.svh
// ----------------------------------------------------------------------------
// Clock time/date setter assertion macros
// Concurrent assertion helpers shared by the setter RTL.
// ----------------------------------------------------------------------------
`ifndef CLOCK_TIME_DATE_SETTER_CORE_DEFINES_SVH
`define CLOCK_TIME_DATE_SETTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTDS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ctds_pkg.sv
// ----------------------------------------------------------------------------
// Clock time/date setter package
// Payload types, codes and calendar helpers for the setter block.
// ----------------------------------------------------------------------------
package ctds_pkg;

  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned MinutesPerHr  = 60;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned YearMax       = 99;

  typedef enum logic [2:0] {
    CMD_SNAP = 3'd0,
    CMD_MODE = 3'd1,
    CMD_BTN1 = 3'd2,
    CMD_BTN2 = 3'd3,
    CMD_BTN3 = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_SHOW = 2'd0,
    MODE_TIME = 2'd1,
    MODE_DATE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TIME = 2'd1,
    KIND_DATE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] snap_hour;
    logic [5:0] snap_minute;
    logic [4:0] snap_date;
    logic [3:0] snap_month;
    logic [6:0] snap_year;
  } in_item_t;

  typedef struct packed {
    logic [1:0] write_kind;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [4:0] out_date;
    logic [3:0] out_month;
    logic [6:0] out_year;
    logic [1:0] current_mode;
  } out_item_t;

  typedef struct packed {
    mode_e      mode;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
  } edit_state_t;

  // Days in a month; year zero of the two-digit range is not a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] len;
    len = 5'd31;
    case (month) inside
      4'd2: begin
        len = ((year[1:0] == 2'b00) && (year != 7'd0)) ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/ctds_step.sv
// ----------------------------------------------------------------------------
// Clock time/date setter step logic
// Combinational mode and edit-register update for one command.
// ----------------------------------------------------------------------------
module ctds_step (
  input  ctds_pkg::edit_state_t state_i,
  input  ctds_pkg::in_item_t    item_i,
  output ctds_pkg::edit_state_t state_o,
  output ctds_pkg::out_item_t   result_o
);

  ctds_pkg::edit_state_t nxt;
  ctds_pkg::kind_e       kind;
  logic [5:0]            hour_inc;
  logic [6:0]            minute_inc;
  logic [5:0]            date_inc;
  logic [4:0]            month_inc;
  logic [7:0]            year_inc;
  logic [4:0]            date_lim;

  assign hour_inc   = {1'b0, state_i.hour} + 6'd1;
  assign minute_inc = {1'b0, state_i.minute} + 7'd1;
  assign date_inc   = {1'b0, state_i.date} + 6'd1;
  assign month_inc  = {1'b0, state_i.month} + 5'd1;
  assign year_inc   = {1'b0, state_i.year} + 8'd1;
  assign date_lim   = ctds_pkg::month_len(state_i.month, state_i.year);

  always_comb begin
    nxt  = state_i;
    kind = ctds_pkg::KIND_NONE;
    unique case (item_i.command)
      ctds_pkg::CMD_SNAP: begin
        if (state_i.mode == ctds_pkg::MODE_SHOW) begin
          nxt.hour   = item_i.snap_hour;
          nxt.minute = item_i.snap_minute;
          nxt.date   = item_i.snap_date;
          nxt.month  = item_i.snap_month;
          nxt.year   = item_i.snap_year;
        end
      end
      ctds_pkg::CMD_MODE: begin
        unique case (state_i.mode)
          ctds_pkg::MODE_SHOW: begin
            // Out-of-range snapshot hour and minute values are cleared before the first time write.
            nxt.mode = ctds_pkg::MODE_TIME;
            if (state_i.hour >= 5'(ctds_pkg::HoursPerDay)) begin
              nxt.hour = '0;
            end
            if (state_i.minute >= 6'(ctds_pkg::MinutesPerHr)) begin
              nxt.minute = '0;
            end
            kind = ctds_pkg::KIND_TIME;
          end
          ctds_pkg::MODE_TIME: begin
            nxt.mode = ctds_pkg::MODE_DATE;
            kind     = ctds_pkg::KIND_DATE;
          end
          default: begin
            nxt.mode = ctds_pkg::MODE_SHOW;
          end
        endcase
      end
      ctds_pkg::CMD_BTN1: begin
        if (state_i.mode == ctds_pkg::MODE_TIME) begin
          nxt.hour = (hour_inc >= 6'(ctds_pkg::HoursPerDay)) ? 5'd0 : hour_inc[4:0];
          kind     = ctds_pkg::KIND_TIME;
        end else if (state_i.mode == ctds_pkg::MODE_DATE) begin
          nxt.date = (date_inc > {1'b0, date_lim}) ? 5'd1 : date_inc[4:0];
          kind     = ctds_pkg::KIND_DATE;
        end
      end
      ctds_pkg::CMD_BTN2: begin
        if (state_i.mode == ctds_pkg::MODE_TIME) begin
          nxt.minute = (minute_inc >= 7'(ctds_pkg::MinutesPerHr)) ? 6'd0 : minute_inc[5:0];
          kind       = ctds_pkg::KIND_TIME;
        end else if (state_i.mode == ctds_pkg::MODE_DATE) begin
          nxt.month = (month_inc > 5'(ctds_pkg::MonthsPerYear)) ? 4'd1 : month_inc[3:0];
          kind      = ctds_pkg::KIND_DATE;
        end
      end
      ctds_pkg::CMD_BTN3: begin
        if (state_i.mode == ctds_pkg::MODE_TIME) begin
          nxt.mode = ctds_pkg::MODE_SHOW;
        end else if (state_i.mode == ctds_pkg::MODE_DATE) begin
          nxt.year = (year_inc > 8'(ctds_pkg::YearMax)) ? 7'd0 : year_inc[6:0];
          kind     = ctds_pkg::KIND_DATE;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o = nxt;

  always_comb begin
    result_o.write_kind   = kind;
    result_o.out_hour     = nxt.hour;
    result_o.out_minute   = nxt.minute;
    result_o.out_date     = nxt.date;
    result_o.out_month    = nxt.month;
    result_o.out_year     = nxt.year;
    result_o.current_mode = nxt.mode;
  end

endmodule

### hw/rtl/clock_time_date_setter_core.sv
// ----------------------------------------------------------------------------
// Clock time/date setter core
// Button and snapshot driven editor for the time and date of a clock.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake                | Payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (ctds_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (ctds_pkg::out_item_t)
//
// One item per cycle while the output is not stalled; an input item passes through
// the input register and then the result register before its result is offered,
// with the mode and edit-register update between them.
// Reset puts the block in show mode with all edit registers at zero.
// A stalled result holds the result register; one more item may wait in the
// input register before in_ready_o drops.
// ----------------------------------------------------------------------------
`include "clock_time_date_setter_core_defines.svh"

module clock_time_date_setter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ctds_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ctds_pkg::out_item_t out_data_o
);

  logic                  in_valid_q;
  logic                  in_valid_d;
  ctds_pkg::in_item_t    in_data_q;
  logic                  out_valid_q;
  logic                  out_valid_d;
  ctds_pkg::out_item_t   out_data_q;
  ctds_pkg::edit_state_t state_q;
  ctds_pkg::edit_state_t state_d;
  ctds_pkg::out_item_t   result;
  logic                  advance;
  logic                  in_xfer;

  // The held item moves on whenever the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  ctds_step u_step (
    .state_i  (state_q),
    .item_i   (in_data_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: ctds_pkg::MODE_SHOW, default: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `CTDS_ASSERT_IMPL(a_time_write_mode, clk_i, rst_ni,
    out_valid_q && (out_data_q.write_kind == ctds_pkg::KIND_TIME),
    out_data_q.current_mode == ctds_pkg::MODE_TIME, "time write outside set-time mode")
  `CTDS_ASSERT_IMPL(a_date_write_mode, clk_i, rst_ni,
    out_valid_q && (out_data_q.write_kind == ctds_pkg::KIND_DATE),
    out_data_q.current_mode == ctds_pkg::MODE_DATE, "date write outside set-date mode")
  `CTDS_ASSERT_IMPL(a_time_write_range, clk_i, rst_ni,
    out_valid_q && (out_data_q.write_kind == ctds_pkg::KIND_TIME),
    (out_data_q.out_hour < 5'd24) && (out_data_q.out_minute < 6'd60), "time write out of range")
  `CTDS_ASSERT_NEXT(a_result_fills, clk_i, rst_ni,
    in_valid_q && !out_valid_q, out_valid_q, "held item did not reach the result register")
  `CTDS_ASSERT_NEXT(a_result_drains, clk_i, rst_ni,
    out_valid_q && out_ready_i && !in_valid_q, !out_valid_q, "result repeated after transfer")

endmodule
